// File: rtl/core/qiv_pkg.sv
// ----------------------------------------------------------------------------
// qiv_pkg
// shared types, constants and helper function of the quote intent validator
// ----------------------------------------------------------------------------
`default_nettype none

package qiv_pkg;

    localparam int DEF_VALUE_WIDTH    = 48;
    localparam int DEF_NOTIONAL_SHIFT = 0;

    localparam int ACTION_W = 2;
    localparam int TAG_W    = 32;
    localparam int VER_W    = 16;
    localparam int SEQ_W    = 48;
    localparam int SIDES_W  = 2;
    localparam int TICK_W   = 47;
    localparam int MINN_W   = 62;
    localparam int BPS_W    = 17;
    localparam int CODE_W   = 4;
    localparam int SIDE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MINN_W;

    // fixed part of the input word ahead of the price and quantity fields
    localparam int HEAD_W = ACTION_W + TAG_W + VER_W + 2 * SEQ_W + SIDES_W;

    localparam logic [13:0] BPS_SCALE = 14'd10000;

    localparam logic [ACTION_W-1:0] ACT_QUOTE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PULL    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_HOLD    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

    localparam logic [CODE_W-1:0] REJ_NONE        = 4'd0;
    localparam logic [CODE_W-1:0] REJ_BAD_ACTION  = 4'd1;
    localparam logic [CODE_W-1:0] REJ_ID_MISSING  = 4'd2;
    localparam logic [CODE_W-1:0] REJ_ID_MISMATCH = 4'd3;
    localparam logic [CODE_W-1:0] REJ_STALE_SEQ   = 4'd4;
    localparam logic [CODE_W-1:0] REJ_NOT_LOADED  = 4'd5;
    localparam logic [CODE_W-1:0] REJ_PRICE       = 4'd6;
    localparam logic [CODE_W-1:0] REJ_NEG_QTY     = 4'd7;
    localparam logic [CODE_W-1:0] REJ_ZERO_QTY    = 4'd8;
    localparam logic [CODE_W-1:0] REJ_TICK        = 4'd9;
    localparam logic [CODE_W-1:0] REJ_LOT         = 4'd10;
    localparam logic [CODE_W-1:0] REJ_MAX_QTY     = 4'd11;
    localparam logic [CODE_W-1:0] REJ_NOTIONAL    = 4'd12;
    localparam logic [CODE_W-1:0] REJ_DISTANCE    = 4'd13;
    localparam logic [CODE_W-1:0] REJ_CROSSED     = 4'd14;

    localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BID  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_ASK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_SEQ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_QTY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NOTL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPS  = 3'd7;

    typedef struct packed {
        logic [TAG_W-1:0]  expected_tag;
        logic [VER_W-1:0]  expected_version;
        logic              require_sequence;
        logic [TICK_W-1:0] price_step;
        logic [TICK_W-1:0] qty_step;
        logic [TICK_W-1:0] max_quantity;
        logic [MINN_W-1:0] notional_floor;
        logic [BPS_W-1:0]  max_distance_bps;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              run;
        logic [CODE_W-1:0] code;
        logic [SIDES_W-1:0] sides;
        logic              crossed;
    } hdr_t;

    // one restoring remainder step
    function automatic logic [TICK_W-1:0] rem_step(input logic [TICK_W-1:0] r,
                                                   input logic b,
                                                   input logic [TICK_W-1:0] dv);
        logic [TICK_W:0] t;
        t = {r, b};
        if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
        end
        return t[TICK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/qiv_lane.sv
// ----------------------------------------------------------------------------
// qiv_lane
// per-side check pipeline: sign checks, products, compares, pipelined remainders
// ----------------------------------------------------------------------------
`default_nettype none

module qiv_lane #(
    parameter int VALUE_WIDTH    = qiv_pkg::DEF_VALUE_WIDTH,
    parameter int NOTIONAL_SHIFT = qiv_pkg::DEF_NOTIONAL_SHIFT
) (
    input  wire logic                      aclk,
    input  wire logic                      ce,
    input  wire logic [VALUE_WIDTH-1:0]    price,
    input  wire logic [VALUE_WIDTH-1:0]    qty,
    input  wire logic [VALUE_WIDTH-1:0]    touch,
    input  wire qiv_pkg::cfg_t             cfg,
    output logic [qiv_pkg::CODE_W-1:0]     code
);
    import qiv_pkg::*;

    localparam int M = VALUE_WIDTH - 1;

    typedef struct packed {
        logic [M-1:0]      pm;
        logic [M-1:0]      qm;
        logic [TICK_W-1:0] rp;
        logic [TICK_W-1:0] rq;
        logic [CODE_W-1:0] early;
        logic              maxq;
        logic              low;
        logic              far;
    } lane_stage_t;

    // stage a
    logic [M-1:0]      a_pm_reg, a_qm_reg, a_d_reg, a_t_reg;
    logic              a_tpos_reg;
    logic [CODE_W-1:0] a_early_reg;
    logic [CODE_W-1:0] early_next;
    logic [M-1:0]      d_next;

    always_comb begin
        priority if ($signed(price) <= 0) begin
            early_next = REJ_PRICE;
        end else if ($signed(qty) < 0) begin
            early_next = REJ_NEG_QTY;
        end else if (qty == '0) begin
            early_next = REJ_ZERO_QTY;
        end else begin
            early_next = REJ_NONE;
        end
        if (price[M-1:0] > touch[M-1:0]) begin
            d_next = price[M-1:0] - touch[M-1:0];
        end else begin
            d_next = touch[M-1:0] - price[M-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_pm_reg    <= price[M-1:0];
            a_qm_reg    <= qty[M-1:0];
            a_t_reg     <= touch[M-1:0];
            a_d_reg     <= d_next;
            a_tpos_reg  <= $signed(touch) > 0;
            a_early_reg <= early_next;
        end
    end

    // stage b: partial products
    logic [63:0] pe, qe, de, te;
    assign pe = 64'(a_pm_reg);
    assign qe = 64'(a_qm_reg);
    assign de = 64'(a_d_reg);
    assign te = 64'(a_t_reg);

    logic [63:0] b_nll_reg, b_nlh_reg, b_nhl_reg, b_nhh_reg;
    logic [63:0] b_dl_reg, b_dh_reg, b_tl_reg, b_th_reg;
    logic [M-1:0] b_pm_reg, b_qm_reg;
    logic         b_tpos_reg, b_maxq_reg;
    logic [CODE_W-1:0] b_early_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_nll_reg   <= pe[31:0] * qe[31:0];
            b_nlh_reg   <= pe[31:0] * qe[63:32];
            b_nhl_reg   <= pe[63:32] * qe[31:0];
            b_nhh_reg   <= pe[63:32] * qe[63:32];
            b_dl_reg    <= 64'(de[31:0]) * 64'(BPS_SCALE);
            b_dh_reg    <= 64'(de[63:32]) * 64'(BPS_SCALE);
            b_tl_reg    <= 64'(te[31:0]) * 64'(cfg.max_distance_bps);
            b_th_reg    <= 64'(te[63:32]) * 64'(cfg.max_distance_bps);
            b_pm_reg    <= a_pm_reg;
            b_qm_reg    <= a_qm_reg;
            b_tpos_reg  <= a_tpos_reg;
            b_early_reg <= a_early_reg;
            b_maxq_reg  <= (cfg.max_quantity != '0) && (qe > 64'(cfg.max_quantity));
        end
    end

    // stage c: sums
    logic [127:0] c_prod_reg, c_lhs_reg, c_rhs_reg;
    logic [M-1:0] c_pm_reg, c_qm_reg;
    logic         c_tpos_reg, c_maxq_reg;
    logic [CODE_W-1:0] c_early_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_prod_reg  <= (128'(b_nhh_reg) << 64) + (128'(b_nlh_reg) << 32)
                         + (128'(b_nhl_reg) << 32) + 128'(b_nll_reg);
            c_lhs_reg   <= (128'(b_dh_reg) << 32) + 128'(b_dl_reg);
            c_rhs_reg   <= (128'(b_th_reg) << 32) + 128'(b_tl_reg);
            c_pm_reg    <= b_pm_reg;
            c_qm_reg    <= b_qm_reg;
            c_tpos_reg  <= b_tpos_reg;
            c_maxq_reg  <= b_maxq_reg;
            c_early_reg <= b_early_reg;
        end
    end

    // stage d and remainder stages
    lane_stage_t dv_reg [0:M];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_reg[0].pm    <= c_pm_reg;
            dv_reg[0].qm    <= c_qm_reg;
            dv_reg[0].rp    <= '0;
            dv_reg[0].rq    <= '0;
            dv_reg[0].early <= c_early_reg;
            dv_reg[0].maxq  <= c_maxq_reg;
            dv_reg[0].low   <= (cfg.notional_floor != '0)
                             && ((c_prod_reg >> NOTIONAL_SHIFT) < 128'(cfg.notional_floor));
            dv_reg[0].far   <= (cfg.max_distance_bps != '0) && c_tpos_reg
                             && (c_lhs_reg > c_rhs_reg);
            for (int j = 0; j < M; j++) begin
                dv_reg[j+1].pm    <= dv_reg[j].pm;
                dv_reg[j+1].qm    <= dv_reg[j].qm;
                dv_reg[j+1].early <= dv_reg[j].early;
                dv_reg[j+1].maxq  <= dv_reg[j].maxq;
                dv_reg[j+1].low   <= dv_reg[j].low;
                dv_reg[j+1].far   <= dv_reg[j].far;
                dv_reg[j+1].rp    <= rem_step(dv_reg[j].rp, dv_reg[j].pm[M-1-j],
                                              cfg.price_step);
                dv_reg[j+1].rq    <= rem_step(dv_reg[j].rq, dv_reg[j].qm[M-1-j],
                                              cfg.qty_step);
            end
        end
    end

    logic [CODE_W-1:0] code_reg, code_next;

    always_comb begin
        priority if (dv_reg[M].early != REJ_NONE) begin
            code_next = dv_reg[M].early;
        end else if (dv_reg[M].rp != '0) begin
            code_next = REJ_TICK;
        end else if (dv_reg[M].rq != '0) begin
            code_next = REJ_LOT;
        end else if (dv_reg[M].maxq) begin
            code_next = REJ_MAX_QTY;
        end else if (dv_reg[M].low) begin
            code_next = REJ_NOTIONAL;
        end else if (dv_reg[M].far) begin
            code_next = REJ_DISTANCE;
        end else begin
            code_next = REJ_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

`default_nettype wire

// File: rtl/core/qiv_merge.sv
// ----------------------------------------------------------------------------
// qiv_merge
// aligns the intent-level checks with the lanes and forms the final result
// ----------------------------------------------------------------------------
`default_nettype none

module qiv_merge #(
    parameter int LAT = qiv_pkg::DEF_VALUE_WIDTH + 4
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      ce,
    input  wire qiv_pkg::hdr_t             hdr_in,
    input  wire logic [qiv_pkg::CODE_W-1:0] bid_code,
    input  wire logic [qiv_pkg::CODE_W-1:0] ask_code,
    output logic                           out_valid,
    output logic [qiv_pkg::CODE_W-1:0]     rejection,
    output logic [qiv_pkg::SIDE_W-1:0]     failing_side
);
    import qiv_pkg::*;

    hdr_t hdr_reg [0:LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                hdr_reg[i].valid <= 1'b0;
            end
        end else if (ce) begin
            hdr_reg[0] <= hdr_in;
            for (int i = 1; i < LAT; i++) begin
                hdr_reg[i] <= hdr_reg[i-1];
            end
        end
    end

    hdr_t              h;
    logic [CODE_W-1:0] rej_next;
    logic [SIDE_W-1:0] side_next;

    assign h = hdr_reg[LAT-1];

    always_comb begin
        rej_next  = REJ_NONE;
        side_next = SIDE_NONE;
        priority if (!h.run) begin
            rej_next = h.code;
        end else if (h.sides[0] && bid_code != REJ_NONE) begin
            rej_next  = bid_code;
            side_next = SIDE_BID;
        end else if (h.sides[1] && ask_code != REJ_NONE) begin
            rej_next  = ask_code;
            side_next = SIDE_ASK;
        end else if (h.sides == 2'b11 && h.crossed) begin
            rej_next = REJ_CROSSED;
        end else begin
            rej_next = REJ_NONE;
        end
    end

    logic              valid_reg;
    logic [CODE_W-1:0] rej_reg;
    logic [SIDE_W-1:0] side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= h.valid;
            rej_reg   <= rej_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid    = valid_reg;
    assign rejection    = rej_reg;
    assign failing_side = side_reg;

    a_side_code: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && side_reg != SIDE_NONE |-> rej_reg >= REJ_PRICE && rej_reg <= REJ_DISTANCE)
        else $error("side set for an intent-level code");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> rej_reg <= REJ_CROSSED && side_reg != 2'd3)
        else $error("result out of range");

    a_pass_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        ce && h.valid && !h.run && h.code == REJ_NONE |=> valid_reg && rej_reg == REJ_NONE)
        else $error("pass-through intent rejected");

endmodule

`default_nettype wire

// File: rtl/core/quote_intent_validator.sv
// ----------------------------------------------------------------------------
// quote_intent_validator
// pre-trade check of one two-sided quote intent, bid and ask in parallel lanes
// throughput: one intent per cycle while the output is not stalled; remainder checks are pipelined one bit a stage
// the whole pipeline advances whenever the output register is empty or taken
// reset (aresetn, synchronous, low) clears the valid bits and the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module quote_intent_validator #(
    parameter int VALUE_WIDTH    = qiv_pkg::DEF_VALUE_WIDTH,
    parameter int NOTIONAL_SHIFT = qiv_pkg::DEF_NOTIONAL_SHIFT,
    localparam int S_TDATA_W = ((qiv_pkg::HEAD_W + 6 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [qiv_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [qiv_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // action, identity_tag, identity_version, intent_sequence, book_sequence,
    // quote_sides, bid_px, bid_qty, ask_px, ask_qty,
    // touch_bid, touch_ask
    input  wire logic [S_TDATA_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // rejection, failing_side
    output logic [7:0]                          m_tdata
);
    import qiv_pkg::*;

    localparam int VW      = VALUE_WIDTH;
    localparam int OFF_TAG = ACTION_W;
    localparam int OFF_VER = OFF_TAG + TAG_W;
    localparam int OFF_ISQ = OFF_VER + VER_W;
    localparam int OFF_BSQ = OFF_ISQ + SEQ_W;
    localparam int OFF_SDS = OFF_BSQ + SEQ_W;
    localparam int OFF_BP  = OFF_SDS + SIDES_W;
    localparam int OFF_BQ  = OFF_BP + VW;
    localparam int OFF_AP  = OFF_BQ + VW;
    localparam int OFF_AQ  = OFF_AP + VW;
    localparam int OFF_TB  = OFF_AQ + VW;
    localparam int OFF_TA  = OFF_TB + VW;
    localparam int LANE_LAT = VALUE_WIDTH + 4;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TAG:      cfg_reg.expected_tag     <= cfg_wr_data[TAG_W-1:0];
                CFG_VERSION:  cfg_reg.expected_version <= cfg_wr_data[VER_W-1:0];
                CFG_REQ_SEQ:  cfg_reg.require_sequence <= cfg_wr_data[0];
                CFG_TICK:     cfg_reg.price_step       <= cfg_wr_data[TICK_W-1:0];
                CFG_LOT:      cfg_reg.qty_step         <= cfg_wr_data[TICK_W-1:0];
                CFG_MAX_QTY:  cfg_reg.max_quantity     <= cfg_wr_data[TICK_W-1:0];
                CFG_MIN_NOTL: cfg_reg.notional_floor   <= cfg_wr_data[MINN_W-1:0];
                CFG_MAX_BPS:  cfg_reg.max_distance_bps <= cfg_wr_data[BPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic [ACTION_W-1:0] action;
    logic [TAG_W-1:0]    tag;
    logic [VER_W-1:0]    ver;
    logic [SEQ_W-1:0]    iseq, bseq;
    logic [SIDES_W-1:0]  sides;
    logic [VW-1:0]       bp, bq, ap, aq, tb, ta;

    assign action = s_tdata[0 +: ACTION_W];
    assign tag    = s_tdata[OFF_TAG +: TAG_W];
    assign ver    = s_tdata[OFF_VER +: VER_W];
    assign iseq   = s_tdata[OFF_ISQ +: SEQ_W];
    assign bseq   = s_tdata[OFF_BSQ +: SEQ_W];
    assign sides  = s_tdata[OFF_SDS +: SIDES_W];
    assign bp     = s_tdata[OFF_BP +: VW];
    assign bq     = s_tdata[OFF_BQ +: VW];
    assign ap     = s_tdata[OFF_AP +: VW];
    assign aq     = s_tdata[OFF_AQ +: VW];
    assign tb     = s_tdata[OFF_TB +: VW];
    assign ta     = s_tdata[OFF_TA +: VW];

    hdr_t hdr;

    always_comb begin
        hdr         = '0;
        hdr.valid   = s_tvalid && ce;
        hdr.sides   = sides;
        hdr.crossed = $signed(bp) >= $signed(ap);
        unique case (action)
            ACT_PULL, ACT_HOLD: begin
                hdr.code = REJ_NONE;
            end
            ACT_UNKNOWN: begin
                hdr.code = REJ_BAD_ACTION;
            end
            ACT_QUOTE: begin
                priority if (tag == '0) begin
                    hdr.code = REJ_ID_MISSING;
                end else if (tag != cfg_reg.expected_tag
                             || ver != cfg_reg.expected_version) begin
                    hdr.code = REJ_ID_MISMATCH;
                end else if (cfg_reg.require_sequence && iseq != bseq) begin
                    hdr.code = REJ_STALE_SEQ;
                end else if (cfg_reg.price_step == '0 || cfg_reg.qty_step == '0) begin
                    hdr.code = REJ_NOT_LOADED;
                end else if (sides == '0) begin
                    hdr.code = REJ_BAD_ACTION;
                end else begin
                    hdr.run = 1'b1;
                end
            end
            default: ;
        endcase
    end

    logic [CODE_W-1:0] bid_code, ask_code;

    qiv_lane #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .NOTIONAL_SHIFT (NOTIONAL_SHIFT)
    ) u_bid_lane (
        .aclk  (aclk),
        .ce    (ce),
        .price (bp),
        .qty   (bq),
        .touch (tb),
        .cfg   (cfg_reg),
        .code  (bid_code)
    );

    qiv_lane #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .NOTIONAL_SHIFT (NOTIONAL_SHIFT)
    ) u_ask_lane (
        .aclk  (aclk),
        .ce    (ce),
        .price (ap),
        .qty   (aq),
        .touch (ta),
        .cfg   (cfg_reg),
        .code  (ask_code)
    );

    logic [CODE_W-1:0] rejection;
    logic [SIDE_W-1:0] failing_side;

    qiv_merge #(
        .LAT (LANE_LAT)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ce           (ce),
        .hdr_in       (hdr),
        .bid_code     (bid_code),
        .ask_code     (ask_code),
        .out_valid    (m_tvalid),
        .rejection    (rejection),
        .failing_side (failing_side)
    );

    assign m_tdata = {2'b00, failing_side, rejection};

endmodule

`default_nettype wire

// File: dv/quote_intent_validator_test.sv
// ----------------------------------------------------------------------------
// quote_intent_validator_test
// self-checking bench: drives quote intents over the input stream and checks
// each rejection code and failing side against an in-bench prediction of the
// venue rules, under several register settings and random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quote_intent_validator_test;
    import qiv_pkg::*;

    localparam int VW = 48;
    localparam int S_W = ((HEAD_W + 6 * VW + 7) / 8) * 8;
    localparam int LATENCY = VW + 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam longint unsigned VAL_MAX = 64'h0000_7fff_ffff_ffff;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0] tag;
        logic [VER_W-1:0] ver;
        logic [SEQ_W-1:0] iseq;
        logic [SEQ_W-1:0] bseq;
        logic [SIDES_W-1:0] sides;
        logic signed [VW-1:0] bp, bq, ap, aq, tb, ta;
    } intent_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;

    cfg_t rules;
    logic [CODE_W+SIDE_W-1:0] verdicts[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int code_seen[16];
    int cycles = 0;
    int stall_left = 0;
    bit no_gaps = 0;
    bit no_stall = 0;

    quote_intent_validator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls and comparison
    always @(posedge aclk) begin
        logic nxt;
        logic [CODE_W+SIDE_W-1:0] exp_v;
        nxt = m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            checked++;
            if (verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                exp_v = verdicts.pop_front();
                code_seen[exp_v[CODE_W-1:0]]++;
                if (m_tdata[3:0] !== exp_v[CODE_W-1:0]) begin
                    errors++;
                    $display("%0t: rejection mismatch, expected %0d, actual %0d",
                             $time, exp_v[CODE_W-1:0], m_tdata[3:0]);
                end
                if (m_tdata[5:4] !== exp_v[CODE_W+SIDE_W-1:CODE_W]) begin
                    errors++;
                    $display("%0t: failing side mismatch, expected %0d, actual %0d",
                             $time, exp_v[CODE_W+SIDE_W-1:CODE_W], m_tdata[5:4]);
                end
            end
            stall_left = no_stall ? 0 : $urandom_range(0, 18);
        end
        if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
        end else begin
            nxt = 1'b1;
        end
        m_tready <= nxt;
    end

    function automatic logic [CODE_W-1:0] side_verdict(logic signed [VW-1:0] price,
                                                       logic signed [VW-1:0] qty,
                                                       logic signed [VW-1:0] touch);
        longint unsigned p, q, t, d;
        logic [127:0] lhs, rhs;
        if (price <= 0) return REJ_PRICE;
        if (qty < 0) return REJ_NEG_QTY;
        if (qty == 0) return REJ_ZERO_QTY;
        p = 64'(price);
        q = 64'(qty);
        if (p % 64'(rules.price_step) != 0) return REJ_TICK;
        if (q % 64'(rules.qty_step) != 0) return REJ_LOT;
        if (rules.max_quantity != 0 && q > 64'(rules.max_quantity)) return REJ_MAX_QTY;
        if (rules.notional_floor != 0) begin
            lhs = 128'(p) * 128'(q);
            if (lhs < 128'(rules.notional_floor)) return REJ_NOTIONAL;
        end
        if (rules.max_distance_bps != 0 && touch > 0) begin
            t = 64'(touch);
            d = p > t ? p - t : t - p;
            lhs = 128'(d) * 128'(BPS_SCALE);
            rhs = 128'(rules.max_distance_bps) * 128'(t);
            if (lhs > rhs) return REJ_DISTANCE;
        end
        return REJ_NONE;
    endfunction

    function automatic logic [CODE_W+SIDE_W-1:0] judge_intent(intent_t it);
        logic [CODE_W-1:0] code;
        logic [SIDE_W-1:0] side;
        code = REJ_NONE;
        side = SIDE_NONE;
        if (it.action == ACT_PULL || it.action == ACT_HOLD) code = REJ_NONE;
        else if (it.action != ACT_QUOTE) code = REJ_BAD_ACTION;
        else if (it.tag == 0) code = REJ_ID_MISSING;
        else if (it.tag != rules.expected_tag || it.ver != rules.expected_version)
            code = REJ_ID_MISMATCH;
        else if (rules.require_sequence && it.iseq != it.bseq) code = REJ_STALE_SEQ;
        else if (rules.price_step == 0 || rules.qty_step == 0) code = REJ_NOT_LOADED;
        else if (it.sides == 0) code = REJ_BAD_ACTION;
        else begin
            if (it.sides[0]) begin
                code = side_verdict(it.bp, it.bq, it.tb);
                if (code != REJ_NONE) side = SIDE_BID;
            end
            if (code == REJ_NONE && it.sides[1]) begin
                code = side_verdict(it.ap, it.aq, it.ta);
                if (code != REJ_NONE) side = SIDE_ASK;
            end
            if (code == REJ_NONE && it.sides == 2'b11 && it.bp >= it.ap) code = REJ_CROSSED;
        end
        return {side, code};
    endfunction

    function automatic logic [47:0] rnd48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TAG:      rules.expected_tag = val[TAG_W-1:0];
            CFG_VERSION:  rules.expected_version = val[VER_W-1:0];
            CFG_REQ_SEQ:  rules.require_sequence = val[0];
            CFG_TICK:     rules.price_step = val[TICK_W-1:0];
            CFG_LOT:      rules.qty_step = val[TICK_W-1:0];
            CFG_MAX_QTY:  rules.max_quantity = val[TICK_W-1:0];
            CFG_MIN_NOTL: rules.notional_floor = val[MINN_W-1:0];
            CFG_MAX_BPS:  rules.max_distance_bps = val[BPS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_rules(logic [31:0] tag, logic [15:0] ver, bit req,
                              longint unsigned tick, longint unsigned lot,
                              longint unsigned maxq, longint unsigned minn,
                              int unsigned bps);
        write_reg(CFG_TAG, 62'(tag));
        write_reg(CFG_VERSION, 62'(ver));
        write_reg(CFG_REQ_SEQ, 62'(req));
        write_reg(CFG_TICK, 62'(tick));
        write_reg(CFG_LOT, 62'(lot));
        write_reg(CFG_MAX_QTY, 62'(maxq));
        write_reg(CFG_MIN_NOTL, 62'(minn));
        write_reg(CFG_MAX_BPS, 62'(bps));
    endtask

    // one transfer on the input stream, expectation queued on acceptance
    task automatic send_intent(intent_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_W'({it.ta, it.tb, it.aq, it.ap, it.bq, it.bp, it.sides,
                         it.bseq, it.iseq, it.ver, it.tag, it.action});
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
        verdicts.push_back(judge_intent(it));
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdicts.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic longint unsigned step_limit(longint unsigned stp);
        longint unsigned k;
        k = stp == 0 ? 2000 : VAL_MAX / stp;
        return k > 2000 ? 2000 : k;
    endfunction

    // well-formed quote on the current rules with random content
    function automatic intent_t good_quote();
        intent_t it;
        longint unsigned tk, lt;
        longint signed b, a;
        tk = rules.price_step == 0 ? 1 : rules.price_step;
        lt = rules.qty_step == 0 ? 1 : rules.qty_step;
        it.action = ACT_QUOTE;
        it.tag = rules.expected_tag;
        it.ver = rules.expected_version;
        it.iseq = rnd48();
        it.bseq = it.iseq;
        it.sides = $urandom_range(0, 9) < 7 ? 2'b11 : 2'($urandom_range(1, 2));
        b = tk * $urandom_range(1, 32'(step_limit(tk)));
        a = b + longint'(tk) * (int'($urandom_range(0, 22)) - 2);
        it.bp = VW'(b);
        it.ap = VW'(a);
        it.bq = VW'(lt * $urandom_range(1, 32'(step_limit(lt) > 60 ? 60 : step_limit(lt))));
        it.aq = VW'(lt * $urandom_range(1, 32'(step_limit(lt) > 60 ? 60 : step_limit(lt))));
        it.tb = VW'(b + longint'(tk) * (int'($urandom_range(0, 40)) - 20));
        it.ta = VW'(a + longint'(tk) * (int'($urandom_range(0, 40)) - 20));
        return it;
    endfunction

    function automatic intent_t rough_quote();
        intent_t it;
        it = good_quote();
        if ($urandom_range(0, 99) < 6) it.action = 2'($urandom);
        if ($urandom_range(0, 99) < 5) it.tag = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
        if ($urandom_range(0, 99) < 5) it.ver = 16'($urandom);
        if ($urandom_range(0, 99) < 8) it.bseq = rnd48();
        if ($urandom_range(0, 99) < 4) it.sides = 2'($urandom);
        if ($urandom_range(0, 99) < 5) it.bp = rnd48();
        if ($urandom_range(0, 99) < 5) it.bq = rnd48();
        if ($urandom_range(0, 99) < 5) it.ap = rnd48();
        if ($urandom_range(0, 99) < 5) it.aq = rnd48();
        if ($urandom_range(0, 99) < 5) it.tb = rnd48();
        if ($urandom_range(0, 99) < 5) it.ta = rnd48();
        if ($urandom_range(0, 99) < 4) it.bq = -it.bq;
        if ($urandom_range(0, 99) < 4) it.bp = it.bp + 1;
        if ($urandom_range(0, 99) < 4) it.aq = it.aq + 1;
        return it;
    endfunction

    task automatic test_reset_rules();
        intent_t it;
        it = good_quote();
        it.action = ACT_PULL;    send_intent(it);
        it.action = ACT_HOLD;    send_intent(it);
        it.action = ACT_UNKNOWN; send_intent(it);
        it.action = ACT_QUOTE;   it.tag = 0; send_intent(it);
        it.tag = 32'hffff_ffff;  send_intent(it);
        it.tag = 0; it.ver = 16'hffff; send_intent(it);
        drain();
    endtask

    task automatic test_directed();
        intent_t base, it;
        load_rules(32'h1234_5678, 16'h00a5, 1'b1, 5, 100, 5000, 200000, 50);
        base = good_quote();
        base.bp = 48'sd10000; base.ap = 48'sd10005;
        base.bq = 48'sd1000;  base.aq = 48'sd1000;
        base.tb = 48'sd10000; base.ta = 48'sd10005;
        send_intent(base);
        it = base; it.ver = base.ver + 1; send_intent(it);
        it = base; it.bseq = base.iseq ^ 48'h8000_0000_0000; send_intent(it);
        it = base; it.sides = 2'b00; send_intent(it);
        it = base; it.bp = 0; send_intent(it);
        it = base; it.bp = {1'b1, 47'd0}; send_intent(it);
        it = base; it.bq = -48'sd100; send_intent(it);
        it = base; it.bq = 0; send_intent(it);
        it = base; it.bp = 48'sd10003; send_intent(it);
        it = base; it.bq = 48'sd1050; send_intent(it);
        it = base; it.bq = 48'sd5100; send_intent(it);
        it = base; it.bq = 48'sd10; it.bp = 48'sd10; it.tb = 48'sd10; send_intent(it);
        it = base; it.tb = 48'sd9000; send_intent(it);
        it = base; it.tb = -48'sd1; it.bp = 48'sd5000; send_intent(it);
        it = base; it.aq = {1'b0, {47{1'b1}}}; send_intent(it);
        it = base; it.ap = 48'sd10000; send_intent(it);
        it = base; it.sides = 2'b10; it.ap = 48'sd5; send_intent(it);
        it = base; it.ap = {1'b0, {47{1'b1}}}; send_intent(it);
        drain();
    endtask

    task automatic test_random(int n, bit calm);
        no_gaps = calm;
        no_stall = calm;
        repeat (n) begin
            if ($urandom_range(0, 99) < 3) begin
                no_gaps = ~no_gaps;
                no_stall = $urandom_range(0, 1);
            end
            send_intent(rough_quote());
        end
        no_gaps = 0;
        no_stall = 0;
        drain();
    endtask

    initial begin
        rules = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_rules();
        test_directed();
        load_rules($urandom | 32'd1, 16'($urandom), 1'b0, 1, 1, 0, 0, 0);
        test_random(300, 1'b0);
        load_rules($urandom | 32'd1, 16'($urandom), 1'b1, 25, 1000, 40000, 50000000, 300);
        test_random(300, 1'b1);
        load_rules(32'hffff_ffff, 16'hffff, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX,
                   64'h3fff_ffff_ffff_ffff, 100000);
        test_random(150, 1'b0);
        load_rules(32'd1, 16'd0, 1'b0, 3, 7, 200, 64'd1 << 20, 1);
        test_random(300, 1'b0);
        load_rules(32'h8000_0000, 16'h8000, 1'b0, 64'd1 << 46, 64'd1 << 40, 0, 1, 0);
        test_random(150, 1'b0);
        load_rules($urandom | 32'd1, 16'($urandom), 1'b0, 10, 10, 0, 0, 0);
        write_reg(CFG_TICK, '0);
        test_random(100, 1'b0);
        $display("covered %0d intents, %0d results checked over several rule settings",
                 sent, checked);
        $display("accepted %0d, rejected by quantity %0d, by distance %0d, crossed %0d",
                 code_seen[REJ_NONE], code_seen[REJ_MAX_QTY], code_seen[REJ_DISTANCE],
                 code_seen[REJ_CROSSED]);
        if (errors == 0 && verdicts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/qiv_pkg.sv
rtl/core/qiv_lane.sv
rtl/core/qiv_merge.sv
rtl/core/quote_intent_validator.sv
dv/quote_intent_validator_test.sv
